// ===== src/marching_cubes_cell_mesher_defines.svh =====
// Assertion macros for the cell mesher, clocked on clk with asynchronous reset arst_n
`ifndef MARCHING_CUBES_CELL_MESHER_DEFINES_SVH
`define MARCHING_CUBES_CELL_MESHER_DEFINES_SVH

// check post in the same cycle as pre
`define MCM_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mesher assertion failed");

// check post in the cycle after pre
`define MCM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mesher assertion failed");

`endif

// ===== src/mcm_pkg.sv =====
// Shared types, constants, triangle table and lookup functions of the cell mesher
package mcm_pkg;

	localparam int GRID_EDGE_DEF = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH   = 2;
	localparam int DENS_W        = 8;
	localparam int CUBE_W        = 4;
	localparam int VERT_W        = 13;
	localparam int ROW_W         = 64;
	localparam int ROW_SLOTS     = 16;
	localparam logic [3:0] EDGE_NONE = 4'hF;

	typedef struct packed {
		logic [DENS_W-1:0] corner0;
		logic [DENS_W-1:0] corner1;
		logic [DENS_W-1:0] corner2;
		logic [DENS_W-1:0] corner3;
		logic [DENS_W-1:0] corner4;
		logic [DENS_W-1:0] corner5;
		logic [DENS_W-1:0] corner6;
		logic [DENS_W-1:0] corner7;
		logic [CUBE_W-1:0] cube_x;
		logic [CUBE_W-1:0] cube_y;
		logic [CUBE_W-1:0] cube_z;
	} in_item_t;

	typedef struct packed {
		logic [VERT_W-1:0] vert_x;
		logic [VERT_W-1:0] vert_y;
		logic [VERT_W-1:0] vert_z;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic rd;
		logic pop;
	} qctl_t;

	// one row per case index, first edge in the top nibble, unused slots hold EDGE_NONE
	localparam logic [ROW_W-1:0] TRI_TABLE [256] = '{
		64'hFFFF_FFFF_FFFF_FFFF, 64'h083F_FFFF_FFFF_FFFF, 64'h019F_FFFF_FFFF_FFFF,
		64'h1839_81FF_FFFF_FFFF, 64'h12AF_FFFF_FFFF_FFFF, 64'h0831_2AFF_FFFF_FFFF,
		64'h92A0_29FF_FFFF_FFFF, 64'h2832_A8A9_8FFF_FFFF, 64'h3B2F_FFFF_FFFF_FFFF,
		64'h0B28_B0FF_FFFF_FFFF, 64'h1902_3BFF_FFFF_FFFF, 64'h1B21_9B98_BFFF_FFFF,
		64'h3A1B_A3FF_FFFF_FFFF, 64'h0A10_8A8B_AFFF_FFFF, 64'h3903_B9BA_9FFF_FFFF,
		64'h98AA_8BFF_FFFF_FFFF, 64'h478F_FFFF_FFFF_FFFF, 64'h4307_34FF_FFFF_FFFF,
		64'h0198_47FF_FFFF_FFFF, 64'h4194_7173_1FFF_FFFF, 64'h12A8_47FF_FFFF_FFFF,
		64'h3473_0412_AFFF_FFFF, 64'h92A9_0284_7FFF_FFFF, 64'h2A92_9727_3794_FFFF,
		64'h8473_B2FF_FFFF_FFFF, 64'hB47B_2420_4FFF_FFFF, 64'h9018_4723_BFFF_FFFF,
		64'h47B9_4B9B_2921_FFFF, 64'h3A13_BA78_4FFF_FFFF, 64'h1BA1_4B10_47B4_FFFF,
		64'h4789_0B9B_AB03_FFFF, 64'h47B4_B99B_AFFF_FFFF, 64'h954F_FFFF_FFFF_FFFF,
		64'h9540_83FF_FFFF_FFFF, 64'h0541_50FF_FFFF_FFFF, 64'h8548_3531_5FFF_FFFF,
		64'h12A9_54FF_FFFF_FFFF, 64'h3081_2A49_5FFF_FFFF, 64'h52A5_4240_2FFF_FFFF,
		64'h2A53_2535_4348_FFFF, 64'h9542_3BFF_FFFF_FFFF, 64'h0B20_8B49_5FFF_FFFF,
		64'h0540_1523_BFFF_FFFF, 64'h2152_5828_B485_FFFF, 64'hA3BA_1395_4FFF_FFFF,
		64'h4950_818A_18BA_FFFF, 64'h5405_0B5B_AB03_FFFF, 64'h5485_8AA8_BFFF_FFFF,
		64'h9785_79FF_FFFF_FFFF, 64'h9309_5357_3FFF_FFFF, 64'h0780_1715_7FFF_FFFF,
		64'h1533_57FF_FFFF_FFFF, 64'h9789_57A1_2FFF_FFFF, 64'hA129_5053_0573_FFFF,
		64'h8028_2585_7A52_FFFF, 64'h2A52_5335_7FFF_FFFF, 64'h7957_893B_2FFF_FFFF,
		64'h9579_7292_027B_FFFF, 64'h23B0_1817_8157_FFFF, 64'hB21B_1771_5FFF_FFFF,
		64'h9588_57A1_3A3B_FFFF, 64'h5705_097B_010A_BA0F, 64'hBA0B_03A5_0807_570F,
		64'hBA57_B5FF_FFFF_FFFF, 64'hA65F_FFFF_FFFF_FFFF, 64'h0835_A6FF_FFFF_FFFF,
		64'h9015_A6FF_FFFF_FFFF, 64'h1831_985A_6FFF_FFFF, 64'h1652_61FF_FFFF_FFFF,
		64'h1651_2630_8FFF_FFFF, 64'h9659_0602_6FFF_FFFF, 64'h5985_8252_6328_FFFF,
		64'h23BA_65FF_FFFF_FFFF, 64'hB08B_20A6_5FFF_FFFF, 64'h0192_3B5A_6FFF_FFFF,
		64'h5A61_929B_298B_FFFF, 64'h63B6_5351_3FFF_FFFF, 64'h08B0_B505_15B6_FFFF,
		64'h3B60_3606_5059_FFFF, 64'h6596_9BB9_8FFF_FFFF, 64'h5A64_78FF_FFFF_FFFF,
		64'h4304_7365_AFFF_FFFF, 64'h1905_A684_7FFF_FFFF, 64'hA651_9717_3794_FFFF,
		64'h6126_5147_8FFF_FFFF, 64'h1255_2630_4347_FFFF, 64'h8479_0506_5026_FFFF,
		64'h7397_9432_9596_269F, 64'h3B27_84A6_5FFF_FFFF, 64'h5A64_7242_027B_FFFF,
		64'h0194_7823_B5A6_FFFF, 64'h9219_B294_B7B4_5A6F, 64'h8473_B535_15B6_FFFF,
		64'h51B5_B610_B7B4_04BF, 64'h0590_6503_6B63_847F, 64'h6596_9B47_97B9_FFFF,
		64'hA496_4AFF_FFFF_FFFF, 64'h4A64_9A08_3FFF_FFFF, 64'hA01A_6064_0FFF_FFFF,
		64'h8318_1686_461A_FFFF, 64'h1491_2426_4FFF_FFFF, 64'h3081_2924_9264_FFFF,
		64'h0244_26FF_FFFF_FFFF, 64'h8328_2442_6FFF_FFFF, 64'hA49A_64B2_3FFF_FFFF,
		64'h0822_8B49_A4A6_FFFF, 64'h3B20_1606_461A_FFFF, 64'h6416_1A48_121B_8B1F,
		64'h9649_3691_3B63_FFFF, 64'h8B18_10B6_1914_641F, 64'h3B63_6006_4FFF_FFFF,
		64'h648B_68FF_FFFF_FFFF, 64'h7A67_8A89_AFFF_FFFF, 64'h0730_A709_A67A_FFFF,
		64'hA671_A717_8180_FFFF, 64'hA67A_7117_3FFF_FFFF, 64'h1261_6818_9867_FFFF,
		64'h2692_9167_9093_739F, 64'h7807_0660_2FFF_FFFF, 64'h7326_72FF_FFFF_FFFF,
		64'h23BA_68A8_9867_FFFF, 64'h2072_7B09_767A_9A7F, 64'h1801_781A_767A_23BF,
		64'hB21B_17A6_1671_FFFF, 64'h8968_6791_6B63_136F, 64'h091B_67FF_FFFF_FFFF,
		64'h7807_063B_0B60_FFFF, 64'h7B6F_FFFF_FFFF_FFFF, 64'h76BF_FFFF_FFFF_FFFF,
		64'h308B_76FF_FFFF_FFFF, 64'h019B_76FF_FFFF_FFFF, 64'h8198_31B7_6FFF_FFFF,
		64'hA126_B7FF_FFFF_FFFF, 64'h12A3_086B_7FFF_FFFF, 64'h2902_A96B_7FFF_FFFF,
		64'h6B72_A3A8_3A98_FFFF, 64'h7236_27FF_FFFF_FFFF, 64'h7087_6062_0FFF_FFFF,
		64'h2762_3701_9FFF_FFFF, 64'h1621_8619_8876_FFFF, 64'hA76A_1713_7FFF_FFFF,
		64'hA761_7A18_7108_FFFF, 64'h0370_7A0A_96A7_FFFF, 64'h76A7_A88A_9FFF_FFFF,
		64'h684B_86FF_FFFF_FFFF, 64'h36B3_0604_6FFF_FFFF, 64'h86B8_4690_1FFF_FFFF,
		64'h9469_6393_1B36_FFFF, 64'h6846_B82A_1FFF_FFFF, 64'h12A3_0B06_B046_FFFF,
		64'h4B84_6B02_92A9_FFFF, 64'hA93A_3294_3B36_463F, 64'h8238_4246_2FFF_FFFF,
		64'h0424_62FF_FFFF_FFFF, 64'h1902_3424_6438_FFFF, 64'h1941_4224_6FFF_FFFF,
		64'h8138_6184_66A1_FFFF, 64'hA10A_0660_4FFF_FFFF, 64'h4634_386A_3039_A93F,
		64'hA946_A4FF_FFFF_FFFF, 64'h4957_6BFF_FFFF_FFFF, 64'h0834_95B7_6FFF_FFFF,
		64'h5015_4076_BFFF_FFFF, 64'hB768_3435_4315_FFFF, 64'h954A_1276_BFFF_FFFF,
		64'h6B71_2A08_3495_FFFF, 64'h76B5_4A42_A402_FFFF, 64'h3483_5432_5A52_B76F,
		64'h7237_6254_9FFF_FFFF, 64'h9540_8606_2687_FFFF, 64'h3623_7615_0540_FFFF,
		64'h6286_8721_8485_158F, 64'h954A_1617_6137_FFFF, 64'h16A1_7610_7870_954F,
		64'h40A4_A503_A6A7_37AF, 64'h76A7_A854_A48A_FFFF, 64'h6956_B9B8_9FFF_FFFF,
		64'h36B0_6305_6095_FFFF, 64'h0B80_5B01_556B_FFFF, 64'h6B36_3553_1FFF_FFFF,
		64'h12A9_5B9B_8B56_FFFF, 64'h0B30_6B09_6569_12AF, 64'hB85B_5680_5A52_025F,
		64'h6B36_352A_3A53_FFFF, 64'h5895_2856_2382_FFFF, 64'h9569_6006_2FFF_FFFF,
		64'h1581_8056_8382_628F, 64'h1562_16FF_FFFF_FFFF, 64'h1361_6A38_6569_896F,
		64'hA10A_0695_0560_FFFF, 64'h0385_6AFF_FFFF_FFFF, 64'hA56F_FFFF_FFFF_FFFF,
		64'hB5A7_5BFF_FFFF_FFFF, 64'hB5AB_7583_0FFF_FFFF, 64'h5B75_AB19_0FFF_FFFF,
		64'hA75A_B798_1831_FFFF, 64'hB12B_7175_1FFF_FFFF, 64'h0831_2717_572B_FFFF,
		64'h9759_2790_22B7_FFFF, 64'h7527_2B59_2328_982F, 64'h25A2_3537_5FFF_FFFF,
		64'h8208_5287_5A25_FFFF, 64'h9015_A353_73A2_FFFF, 64'h9829_2187_2A25_752F,
		64'h1353_75FF_FFFF_FFFF, 64'h0870_7117_5FFF_FFFF, 64'h9039_3553_7FFF_FFFF,
		64'h9875_97FF_FFFF_FFFF, 64'h5845_A8AB_8FFF_FFFF, 64'h5045_B05A_BB30_FFFF,
		64'h0198_4A8A_BA45_FFFF, 64'hAB4A_45B3_4941_314F, 64'h2512_852B_8458_FFFF,
		64'h04B0_B345_B2B1_51BF, 64'h0250_592B_5458_B85F, 64'h9452_B3FF_FFFF_FFFF,
		64'h25A3_5234_5384_FFFF, 64'h5A25_2442_0FFF_FFFF, 64'h3A23_5A38_5458_019F,
		64'h5A25_2419_2942_FFFF, 64'h8458_5335_1FFF_FFFF, 64'h0451_05FF_FFFF_FFFF,
		64'h8458_5390_5035_FFFF, 64'h945F_FFFF_FFFF_FFFF, 64'h4B74_9B9A_BFFF_FFFF,
		64'h0834_979B_79AB_FFFF, 64'h1AB1_B414_074B_FFFF, 64'h3143_481A_474B_AB4F,
		64'h4B79_B492_B912_FFFF, 64'h9749_B791_B2B1_083F, 64'hB74B_4224_0FFF_FFFF,
		64'hB74B_4283_4324_FFFF, 64'h29A2_7923_7749_FFFF, 64'h9A79_74A2_7870_207F,
		64'h37A3_A274_A1A0_40AF, 64'h1A28_74FF_FFFF_FFFF, 64'h4914_1771_3FFF_FFFF,
		64'h4914_1708_1871_FFFF, 64'h4037_43FF_FFFF_FFFF, 64'h487F_FFFF_FFFF_FFFF,
		64'h9A8A_B8FF_FFFF_FFFF, 64'h3093_9BB9_AFFF_FFFF, 64'h01A0_A88A_BFFF_FFFF,
		64'h31AB_3AFF_FFFF_FFFF, 64'h12B1_B99B_8FFF_FFFF, 64'h3093_9B12_92B9_FFFF,
		64'h02B8_0BFF_FFFF_FFFF, 64'h32BF_FFFF_FFFF_FFFF, 64'h2382_8AA8_9FFF_FFFF,
		64'h9A20_92FF_FFFF_FFFF, 64'h2382_8A01_81A8_FFFF, 64'h1A2F_FFFF_FFFF_FFFF,
		64'h1389_18FF_FFFF_FFFF, 64'h091F_FFFF_FFFF_FFFF, 64'h038F_FFFF_FFFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFF
	};

	// number of edges listed in a row, up to the first empty slot
	function automatic logic [3:0] tri_count(input logic [ROW_W-1:0] row);
		logic [3:0] n;
		logic       done;
		n    = 4'd0;
		done = 1'b0;
		for (int i = 0; i < ROW_SLOTS; i++) begin
			if (!done) begin
				if (row[ROW_W-1-4*i -: 4] == EDGE_NONE) begin
					done = 1'b1;
				end else begin
					n = 4'(i + 1);
				end
			end
		end
		return n;
	endfunction

	function automatic logic [2:0] edge_start(input logic [3:0] e);
		logic [2:0] c;
		case (e)
			4'd0:    c = 3'd0;
			4'd1:    c = 3'd1;
			4'd2:    c = 3'd2;
			4'd3:    c = 3'd3;
			4'd4:    c = 3'd4;
			4'd5:    c = 3'd5;
			4'd6:    c = 3'd6;
			4'd7:    c = 3'd7;
			4'd8:    c = 3'd0;
			4'd9:    c = 3'd1;
			4'd10:   c = 3'd2;
			4'd11:   c = 3'd3;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] edge_stop(input logic [3:0] e);
		logic [2:0] c;
		case (e)
			4'd0:    c = 3'd1;
			4'd1:    c = 3'd2;
			4'd2:    c = 3'd3;
			4'd3:    c = 3'd0;
			4'd4:    c = 3'd5;
			4'd5:    c = 3'd6;
			4'd6:    c = 3'd7;
			4'd7:    c = 3'd4;
			4'd8:    c = 3'd4;
			4'd9:    c = 3'd5;
			4'd10:   c = 3'd6;
			4'd11:   c = 3'd7;
			default: c = 3'd1;
		endcase
		return c;
	endfunction

	// corner offset packed as {x, y, z}
	function automatic logic [2:0] corner_offset(input logic [2:0] c);
		logic [2:0] o;
		case (c)
			3'd0:    o = 3'b000;
			3'd1:    o = 3'b100;
			3'd2:    o = 3'b101;
			3'd3:    o = 3'b001;
			3'd4:    o = 3'b010;
			3'd5:    o = 3'b110;
			3'd6:    o = 3'b111;
			3'd7:    o = 3'b011;
			default: o = 3'b000;
		endcase
		return o;
	endfunction

	function automatic logic [DENS_W-1:0] corner_of(input in_item_t it, input logic [2:0] c);
		logic [DENS_W-1:0] v;
		case (c)
			3'd0:    v = it.corner0;
			3'd1:    v = it.corner1;
			3'd2:    v = it.corner2;
			3'd3:    v = it.corner3;
			3'd4:    v = it.corner4;
			3'd5:    v = it.corner5;
			3'd6:    v = it.corner6;
			3'd7:    v = it.corner7;
			default: v = it.corner0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/mcm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
module mcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/mcm_mesher.sv =====
// Cube sequencer: case lookup, per-edge interpolation divider and vertex output register
module mcm_mesher #(
	parameter int GRID_EDGE = mcm_pkg::GRID_EDGE_DEF,
	parameter int FRAC_BITS = mcm_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mcm_pkg::DENS_W-1:0]    level,
	input  logic                          avail,
	input  mcm_pkg::in_item_t             item,
	output mcm_pkg::qctl_t                qctl,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mcm_pkg::out_item_t            out_data
);

	localparam int TW  = FRAC_BITS + 1;
	localparam int BCW = $clog2(FRAC_BITS + 1);
	localparam int VW0 = mcm_pkg::CUBE_W + 2 + FRAC_BITS;
	localparam int VW  = (VW0 > mcm_pkg::VERT_W) ? VW0 : mcm_pkg::VERT_W;
	localparam int DW  = mcm_pkg::DENS_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_EDGE = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FORM = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]                        state_q;
	mcm_pkg::in_item_t                 item_q;
	logic [mcm_pkg::ROW_W-1:0]         row_q;
	logic [3:0]                        cnt_q;
	logic [3:0]                        idx_q;
	logic [mcm_pkg::CUBE_W-1:0]        cx_q, cy_q, cz_q;
	logic [2:0]                        s_q, d_q;
	logic [DW-1:0]                     rem_q, div_q;
	logic [TW-1:0]                     t_q;
	logic [BCW-1:0]                    bc_q;
	mcm_pkg::out_item_t                out_q;

	logic [7:0]                        mask;
	logic [mcm_pkg::ROW_W-1:0]         row_new;
	logic [3:0]                        cnt_new;
	logic [3:0]                        edge_code;
	logic [2:0]                        ca, ce, s_n, d_n;
	logic [DW-1:0]                     va, vb, lo, hi;
	logic                              swap;
	logic [DW:0]                       rem2, rem_sub;
	logic                              ge;
	logic                              last_n;
	logic [2:0]                        so, eo;

	function automatic logic [mcm_pkg::CUBE_W-1:0] cube_mod(
		input logic [mcm_pkg::CUBE_W-1:0] v
	);
		logic [8:0] w;
		w = 9'(v);
		for (int i = 0; i < 8; i++) begin
			if (w >= 9'(GRID_EDGE)) begin
				w = w - 9'(GRID_EDGE);
			end
		end
		return w[mcm_pkg::CUBE_W-1:0];
	endfunction

	function automatic logic [mcm_pkg::VERT_W-1:0] vert_axis(
		input logic [mcm_pkg::CUBE_W-1:0] c,
		input logic                       o_s,
		input logic                       o_e,
		input logic [TW-1:0]              t
	);
		logic [VW-1:0] base;
		logic [VW-1:0] v;
		base = VW'({1'b0, c} + 5'(o_s)) << FRAC_BITS;
		v    = base;
		if (o_e && !o_s) begin
			v = base + VW'(t);
		end else if (!o_e && o_s) begin
			v = base - VW'(t);
		end
		return v[mcm_pkg::VERT_W-1:0];
	endfunction

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mask[i] = mcm_pkg::corner_of(item, 3'(i)) > level;
		end
	end

	assign row_new   = mcm_pkg::TRI_TABLE[mask];
	assign cnt_new   = mcm_pkg::tri_count(row_new);
	assign edge_code = row_q[{4'd15 - idx_q, 2'b00} +: 4];
	assign ca        = mcm_pkg::edge_start(edge_code);
	assign ce        = mcm_pkg::edge_stop(edge_code);
	assign va        = mcm_pkg::corner_of(item_q, ca);
	assign vb        = mcm_pkg::corner_of(item_q, ce);
	assign swap      = va > vb;
	assign s_n       = swap ? ce : ca;
	assign d_n       = swap ? ca : ce;
	assign lo        = swap ? vb : va;
	assign hi        = swap ? va : vb;
	assign rem2      = {rem_q, 1'b0};
	assign ge        = rem2 >= {1'b0, div_q};
	assign rem_sub   = rem2 - {1'b0, div_q};
	assign last_n    = idx_q == (cnt_q - 4'd1);
	assign so        = mcm_pkg::corner_offset(s_q);
	assign eo        = mcm_pkg::corner_offset(d_q);

	assign qctl.rd   = (state_q == S_IDLE) && avail;
	assign qctl.pop  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (avail) state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= (cnt_new == 4'd0) ? S_IDLE : S_EDGE;
				end
				S_EDGE: begin
					if (hi <= lo || level < lo || level >= hi) begin
						state_q <= S_FORM;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (bc_q == BCW'(1)) state_q <= S_FORM;
				end
				S_FORM: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) state_q <= out_q.last ? S_IDLE : S_EDGE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				item_q <= item;
				row_q  <= row_new;
				cnt_q  <= cnt_new;
				idx_q  <= 4'd0;
				cx_q   <= cube_mod(item.cube_x);
				cy_q   <= cube_mod(item.cube_y);
				cz_q   <= cube_mod(item.cube_z);
			end
			S_EDGE: begin
				s_q   <= s_n;
				d_q   <= d_n;
				rem_q <= level - lo;
				div_q <= hi - lo;
				bc_q  <= BCW'(FRAC_BITS);
				if (hi <= lo || level < lo) begin
					t_q <= '0;
				end else if (level >= hi) begin
					t_q <= TW'(1) << FRAC_BITS;
				end else begin
					t_q <= '0;
				end
			end
			S_DIV: begin
				// restoring division, one quotient bit per cycle
				t_q   <= {t_q[TW-2:0], ge};
				rem_q <= ge ? rem_sub[DW-1:0] : rem2[DW-1:0];
				bc_q  <= bc_q - BCW'(1);
			end
			S_FORM: begin
				out_q.vert_x <= vert_axis(cx_q, so[2], eo[2], t_q);
				out_q.vert_y <= vert_axis(cy_q, so[1], eo[1], t_q);
				out_q.vert_z <= vert_axis(cz_q, so[0], eo[0], t_q);
				out_q.last   <= last_n;
			end
			S_OUT: begin
				if (!out_stall) idx_q <= idx_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/marching_cubes_cell_mesher.sv =====
// Marching-cubes cell mesher: cubes queue in a two-entry RAM, one sequencer emits vertices.
// Per cube: RAM read, then case lookup; per vertex: edge setup, FRAC_BITS divider steps when the level
// is at least the lower and below the higher corner density of the edge, then forming and output,
// held by output stalls. One cube at a time goes through the single shared restoring divider.
// A cube is taken while the queue holds fewer than two cubes.
// Reset clears the queue pointers, the sequencer and the iso level; RAM contents are not cleared.
`include "marching_cubes_cell_mesher_defines.svh"

module marching_cubes_cell_mesher #(
	parameter int GRID_EDGE = mcm_pkg::GRID_EDGE_DEF,
	parameter int FRAC_BITS = mcm_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  mcm_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output mcm_pkg::out_item_t         out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mcm_pkg::DENS_W-1:0] cfg_data
);

	localparam int QDEPTH = mcm_pkg::QUEUE_DEPTH;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int FW     = $clog2(QDEPTH + 1);
	localparam int IW     = $bits(mcm_pkg::in_item_t);

	logic [mcm_pkg::DENS_W-1:0] iso_level_q;
	logic [QAW-1:0]             wr_ptr_q, rd_ptr_q;
	logic [FW-1:0]              fill_q;
	logic                       accept;
	logic [IW-1:0]              rd_raw;
	mcm_pkg::in_item_t          rd_item;
	mcm_pkg::qctl_t             qctl;

	assign cfg_ready = 1'b1;
	assign in_stall  = (fill_q == FW'(QDEPTH));
	assign accept    = in_valid && !in_stall;
	assign rd_item   = mcm_pkg::in_item_t'(rd_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_level_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			iso_level_q <= cfg_data;
		end
	end

	// queue bookkeeping: writes go only to free entries, reads only to filled ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (qctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			fill_q <= fill_q + FW'(accept) - FW'(qctl.pop);
		end
	end

	mcm_ram #(
		.WIDTH(IW),
		.DEPTH(QDEPTH),
		.AW   (QAW)
	) u_queue (
		.clk  (clk),
		.we   (accept),
		.waddr(wr_ptr_q),
		.wdata(IW'(in_data)),
		.re   (qctl.rd),
		.raddr(rd_ptr_q),
		.rdata(rd_raw)
	);

	mcm_mesher #(
		.GRID_EDGE(GRID_EDGE),
		.FRAC_BITS(FRAC_BITS)
	) u_mesher (
		.clk      (clk),
		.arst_n   (arst_n),
		.level    (iso_level_q),
		.avail    (fill_q != '0),
		.item     (rd_item),
		.qctl     (qctl),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	`MCM_ASSERT_NOW(a_pop_nonempty, qctl.pop, fill_q != '0)
	`MCM_ASSERT_NEXT(a_idle_after_last, out_valid && !out_stall && out_data.last, !out_valid)
	`MCM_ASSERT_NEXT(a_cfg_write, cfg_valid, iso_level_q == $past(cfg_data))

endmodule
